/* design/u8v_pkg.sv */
// u8v_pkg: shared types and constants for the utf-8 structure validator
// depends on nothing; imported by u8v_parser and utf8_structure_validator
package u8v_pkg;

  localparam int unsigned POS_W = 18;
  localparam longint unsigned U8V_MAX_STREAM_BYTES = 64'd262144;
  localparam logic [POS_W-1:0] POS_MASK = {POS_W{1'b1}};

  // byte class prefixes
  localparam logic [1:0] CONT_PREFIX  = 2'h2;
  localparam logic [2:0] LEAD2_PREFIX = 3'h6;
  localparam logic [3:0] LEAD3_PREFIX = 4'hE;
  localparam logic [4:0] LEAD4_PREFIX = 5'h1E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic             is_valid;
    logic [POS_W-1:0] error_offset;
  } out_item_t;

  // highest offset the position counter reaches
  function automatic logic [POS_W-1:0] pos_limit(input longint unsigned max_bytes);
    longint unsigned lim;
    lim = (max_bytes == 64'd0) ? 64'd1 : max_bytes;
    lim = lim - 64'd1;
    if (lim > 64'(POS_MASK)) begin
      lim = 64'(POS_MASK);
    end
    return lim[POS_W-1:0];
  endfunction

endpackage

/* design/u8v_parser.sv */
// u8v_parser: sequence state and per-word parse step, result formed on the last word
// depends on u8v_pkg
module u8v_parser
  import u8v_pkg::*;
#(
  parameter longint unsigned MAX_STREAM_BYTES = U8V_MAX_STREAM_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic [POS_W-1:0] POS_LIMIT = pos_limit(MAX_STREAM_BYTES);

  logic [POS_W-1:0] byte_position_r, byte_position_nxt;
  logic [POS_W-1:0] sequence_start_r, sequence_start_nxt;
  logic [1:0]       pending_r, pending_nxt;
  logic             error_seen_r, error_seen_nxt;
  logic [POS_W-1:0] first_error_r, first_error_nxt;

  logic [7:0]       b;
  logic [1:0]       pend_w;
  logic             err_w;
  logic [POS_W-1:0] seq_w;
  logic [POS_W-1:0] ferr_w;

  assign b = item.data_byte;

  always_comb begin
    pend_w = pending_r;
    err_w  = error_seen_r;
    seq_w  = sequence_start_r;
    ferr_w = first_error_r;
    if (!error_seen_r) begin
      if (pending_r != 2'd0) begin
        if (b[7:6] != CONT_PREFIX) begin
          err_w  = 1'b1;
          ferr_w = sequence_start_r;
          pend_w = 2'd0;
        end else begin
          pend_w = pending_r - 2'd1;
        end
      end else if (!b[7]) begin
        pend_w = 2'd0;
      end else if (b[7:5] == LEAD2_PREFIX) begin
        seq_w  = byte_position_r;
        pend_w = 2'd1;
      end else if (b[7:4] == LEAD3_PREFIX) begin
        seq_w  = byte_position_r;
        pend_w = 2'd2;
      end else if (b[7:3] == LEAD4_PREFIX) begin
        seq_w  = byte_position_r;
        pend_w = 2'd3;
      end else begin
        // stray continuation or invalid lead
        err_w  = 1'b1;
        ferr_w = byte_position_r;
        pend_w = 2'd0;
      end
    end
    // cut-off sequence at end of stream
    if (item.last && !err_w && pend_w != 2'd0) begin
      err_w  = 1'b1;
      ferr_w = seq_w;
      pend_w = 2'd0;
    end
  end

  assign result.is_valid     = !err_w;
  assign result.error_offset = err_w ? ferr_w : '0;

  always_comb begin
    byte_position_nxt  = byte_position_r;
    sequence_start_nxt = sequence_start_r;
    pending_nxt        = pending_r;
    error_seen_nxt     = error_seen_r;
    first_error_nxt    = first_error_r;
    if (step) begin
      if (item.last) begin
        byte_position_nxt  = '0;
        sequence_start_nxt = '0;
        pending_nxt        = 2'd0;
        error_seen_nxt     = 1'b0;
        first_error_nxt    = '0;
      end else begin
        sequence_start_nxt = seq_w;
        pending_nxt        = pend_w;
        error_seen_nxt     = err_w;
        first_error_nxt    = ferr_w;
        if (byte_position_r < POS_LIMIT) begin
          byte_position_nxt = byte_position_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= '0;
      sequence_start_r <= '0;
      pending_r        <= 2'd0;
      error_seen_r     <= 1'b0;
      first_error_r    <= '0;
    end else begin
      byte_position_r  <= byte_position_nxt;
      sequence_start_r <= sequence_start_nxt;
      pending_r        <= pending_nxt;
      error_seen_r     <= error_seen_nxt;
      first_error_r    <= first_error_nxt;
    end
  end

endmodule

/* design/utf8_structure_validator.sv */
// utf8_structure_validator: one word per cycle; input register, parse logic, result register
// result: a last word's verdict is registered in the result register and shown on out_valid
// throughput: one word per cycle; only a last word waits for a free result register
// reset: synchronous active-low rst_n clears the position, sequence and error state
// and both valid flags; the block is ready in the cycle after reset is released
// depends on u8v_pkg and u8v_parser
module utf8_structure_validator
  import u8v_pkg::*;
#(
  parameter longint unsigned MAX_STREAM_BYTES = U8V_MAX_STREAM_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      out_free;
  logic      step;
  out_item_t result;

  assign out_free = !out_vld_r || !out_stall;
  // a plain word always moves on; a last word needs room in the result register
  assign step     = in_vld_r && (!in_item_r.last || out_free);
  assign in_stall = in_vld_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  u8v_parser #(
    .MAX_STREAM_BYTES(MAX_STREAM_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && in_item_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_item_r.last) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_valid_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.is_valid |-> out_item_r.error_offset == '0)
    else $error("valid result carries a non-zero offset");

  a_new_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !$past(out_vld_r && out_stall) |-> $past(step && in_item_r.last))
    else $error("result appeared without a last word");

  a_stall_only_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && in_item_r.last && out_vld_r && out_stall)
    else $error("input stalled without a blocked last word");

endmodule

/* tb/sv/utf8_structure_validator_checker.sv */
// utf8_structure_validator_checker: watches both channels, predicts each verdict, compares
// depends on u8v_pkg; counts mismatches and open verdicts for the testbench top
`timescale 1ns / 1ps

module utf8_structure_validator_checker
  import u8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  in_item_t        in_item,
  input  logic            out_valid,
  input  logic            out_stall,
  input  out_item_t       out_item,
  output int unsigned     fail_count,
  output int unsigned     verdicts_open
);

  // offset at which the position counter stops
  localparam longint unsigned LIMIT_RAW =
    (U8V_MAX_STREAM_BYTES == 64'd0) ? 64'd0 : U8V_MAX_STREAM_BYTES - 64'd1;
  localparam logic [POS_W-1:0] LAST_OFFSET =
    (LIMIT_RAW > 64'(POS_MASK)) ? POS_MASK : POS_W'(LIMIT_RAW);

  logic [POS_W-1:0] at_offset   = '0;
  logic [POS_W-1:0] lead_offset = '0;
  logic [1:0]       owed_conts  = '0;
  logic             broken      = 1'b0;
  logic [POS_W-1:0] broken_at   = '0;

  out_item_t verdicts_due[$];

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic mark_broken(input logic [POS_W-1:0] off);
    if (!broken) begin
      broken    = 1'b1;
      broken_at = off;
    end
    owed_conts = '0;
  endtask

  task automatic scan_byte(input in_item_t w);
    logic [7:0] b;
    out_item_t  v;
    b = w.data_byte;
    // once broken, words are only counted until the last word closes the stream
    if (!broken) begin
      if (owed_conts != 0) begin
        if (b[7:6] != CONT_PREFIX) begin
          mark_broken(lead_offset);
        end else begin
          owed_conts = owed_conts - 2'd1;
        end
      end else if (b[7]) begin
        if (b[7:5] == LEAD2_PREFIX) begin
          lead_offset = at_offset;
          owed_conts  = 2'd1;
        end else if (b[7:4] == LEAD3_PREFIX) begin
          lead_offset = at_offset;
          owed_conts  = 2'd2;
        end else if (b[7:3] == LEAD4_PREFIX) begin
          lead_offset = at_offset;
          owed_conts  = 2'd3;
        end else begin
          // stray continuation or lead above 0xf7
          mark_broken(at_offset);
        end
      end
    end
    if (!w.last) begin
      if (at_offset < LAST_OFFSET) begin
        at_offset = at_offset + 1'b1;
      end
    end else begin
      if (!broken && owed_conts != 0) begin
        mark_broken(lead_offset);
      end
      v.is_valid     = !broken;
      v.error_offset = broken ? broken_at : '0;
      verdicts_due.push_back(v);
      at_offset   = '0;
      lead_offset = '0;
      owed_conts  = '0;
      broken      = 1'b0;
      broken_at   = '0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict valid=%0b offset=%0d with none expected",
                                    out_item.is_valid, out_item.error_offset));
        end else begin
          want = verdicts_due.pop_front();
          if (out_item.is_valid !== want.is_valid) begin
            report_mismatch($sformatf("is_valid %0b, expected %0b",
                                      out_item.is_valid, want.is_valid));
          end
          if (out_item.error_offset !== want.error_offset) begin
            report_mismatch($sformatf("error_offset %0d, expected %0d",
                                      out_item.error_offset, want.error_offset));
          end
        end
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_item);
      end
    end
    verdicts_open <= verdicts_due.size();
  end

endmodule

/* tb/sv/utf8_structure_validator_tb.sv */
// utf8_structure_validator_tb: byte streams for the validator, random idling on both sides
// depends on u8v_pkg, utf8_structure_validator and utf8_structure_validator_checker
`timescale 1ns / 1ps

module utf8_structure_validator_tb;
  import u8v_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int unsigned {FLAW_STRAY, FLAW_LEAD, FLAW_CONT, FLAW_CUT} flaw_t;

  localparam int unsigned WORDS_TARGET = 580;
  localparam int unsigned HOLD_CYCLES  = 120;
  // one long stream of plain words with an invalid lead near its end
  localparam int unsigned LONG_STREAM  = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned verdicts_open;
  int unsigned words_sent = 0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  bit          drain_done = 1'b0;

  utf8_structure_validator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  utf8_structure_validator_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .verdicts_open (verdicts_open)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** utf8_structure_validator: FAILED **");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic byte_q_t make_stream();
    byte_q_t     s;
    int unsigned n_chars;
    int          flaw_at;
    flaw_t       flaw;
    int unsigned width;
    int unsigned slot;
    logic [7:0]  lead;
    n_chars = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
    // raw noise
    if ($urandom_range(0, 9) == 0) begin
      repeat (n_chars * 2) s.push_back(8'($urandom_range(0, 255)));
      return s;
    end
    flaw    = flaw_t'($urandom_range(0, 3));
    flaw_at = -1;
    if ($urandom_range(0, 99) < 35) begin
      flaw_at = (flaw == FLAW_CUT) ? n_chars - 1 : $urandom_range(0, n_chars - 1);
    end
    for (int k = 0; k < n_chars; k++) begin
      width = $urandom_range(1, 4);
      slot  = 0;
      if (k == flaw_at) begin
        if (flaw == FLAW_STRAY) s.push_back({CONT_PREFIX, 6'($urandom)});
        if (flaw == FLAW_LEAD) s.push_back({5'b11111, 3'($urandom)});
        if (flaw == FLAW_CONT || flaw == FLAW_CUT) begin
          if (width == 1) width = $urandom_range(2, 4);
          slot = $urandom_range(1, width - 1);
        end
      end
      case (width)
        1:       lead = {1'b0, 7'($urandom)};
        2:       lead = {LEAD2_PREFIX, 5'($urandom)};
        3:       lead = {LEAD3_PREFIX, 4'($urandom)};
        default: lead = {LEAD4_PREFIX, 3'($urandom)};
      endcase
      s.push_back(lead);
      for (int c = 1; c < width; c++) begin
        if (k == flaw_at && flaw == FLAW_CONT && c == slot) begin
          s.push_back($urandom_range(0, 1) ? {1'b0, 7'($urandom)} : {2'b11, 6'($urandom)});
        end else if (!(k == flaw_at && flaw == FLAW_CUT && c >= slot)) begin
          s.push_back({CONT_PREFIX, 6'($urandom)});
        end
      end
    end
    return s;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic fin);
    in_item_t w;
    w.data_byte = b;
    w.last      = fin;
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_stream(input byte_q_t s, input bit gappy);
    for (int i = 0; i < s.size(); i++) begin
      if (gappy) idle_for(gap_len());
      push_word(s[i], i == s.size() - 1);
    end
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_open != 0) @(posedge clk);
  endtask

  // result side: stretches of no stall, light and heavy stalling, long holds on request
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned stall_run;
    out_stall = 1'b0;
    stall_run = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(posedge clk);
        end else if (stall_run != 0) begin
          out_stall <= 1'b1;
          stall_run--;
        end else if (mode == 0) begin
          out_stall <= 1'b0;
        end else begin
          if ($urandom_range(0, 99) < 2) stall_run = $urandom_range(10, 40);
          out_stall <= (mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  initial begin
    byte_q_t s;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each lead width, every kind of error
    s = '{8'h00};                      send_stream(s, 1'b0);
    s = '{8'h7F, 8'hC2, 8'h80};        send_stream(s, 1'b0);
    s = '{8'hE2, 8'h82, 8'hAC};        send_stream(s, 1'b0);
    s = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_stream(s, 1'b0);
    s = '{8'h41, 8'h80};               send_stream(s, 1'b0);
    s = '{8'hFF};                      send_stream(s, 1'b0);
    s = '{8'hF8, 8'h41};               send_stream(s, 1'b0);
    s = '{8'h41, 8'hE2, 8'h41, 8'h80}; send_stream(s, 1'b0);
    s = '{8'h41, 8'hF0, 8'h90};        send_stream(s, 1'b0);
    drain_verdicts();

    while (words_sent < WORDS_TARGET) begin
      send_stream(make_stream(), $urandom_range(0, 3) != 0);
      if (!hold_done && words_sent >= 200) begin
        // long hold on the result side while short streams keep arriving
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (10) begin
          s = '{{1'b0, 7'($urandom)}};
          send_stream(s, 1'b0);
        end
        drain_verdicts();
      end
      if (!drain_done && words_sent >= 450) begin
        drain_done = 1'b1;
        drain_verdicts();
      end
    end

    idle_for(gap_len());
    for (int i = 0; i < LONG_STREAM; i++) begin
      push_word((i == LONG_STREAM - 3) ? 8'hFF : {1'b0, 7'($urandom)}, i == LONG_STREAM - 1);
    end

    drain_verdicts();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** utf8_structure_validator: PASSED **");
    end else begin
      $display("** utf8_structure_validator: FAILED **");
    end
    $finish;
  end

endmodule
